// File: hw/rtl/tolc_pkg.sv
// Shared types and codes for the timed on/off light controller.
package tolc_pkg;

  // Input item kinds
  localparam logic [3:0] KIND_OFF        = 4'd0;
  localparam logic [3:0] KIND_ON         = 4'd1;
  localparam logic [3:0] KIND_TOGGLE     = 4'd2;
  localparam logic [3:0] KIND_OFF_EFFECT = 4'd3;
  localparam logic [3:0] KIND_ON_RECALL  = 4'd4;
  localparam logic [3:0] KIND_ON_TIMED   = 4'd5;
  localparam logic [3:0] KIND_TICK       = 4'd6;
  localparam logic [3:0] KIND_WR_ON      = 4'd7;
  localparam logic [3:0] KIND_WR_WAIT    = 4'd8;
  localparam logic [3:0] KIND_LEVEL      = 4'd9;
  localparam logic [3:0] KIND_STARTUP    = 4'd10;

  // Result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_CONSTRAINT  = 2'd1;
  localparam logic [1:0] ST_NOOP        = 2'd2;
  localparam logic [1:0] ST_EFFECT_FAIL = 2'd3;

  // Start-up modes
  localparam logic [1:0] SU_OFF    = 2'd0;
  localparam logic [1:0] SU_ON     = 2'd1;
  localparam logic [1:0] SU_TOGGLE = 2'd2;
  localparam logic [1:0] SU_KEEP   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_STARTUP_MODE   = 2'd0;
  localparam logic [1:0] CFG_STARTUP_IS_OTA = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_ON_OFF = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  // Time limits
  localparam logic [15:0] TIME_FOREVER = 16'hFFFF;
  localparam logic [15:0] TIME_ARG_MAX = 16'hFFFE;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] on_time_arg;
    logic [15:0] off_wait_arg;
    logic        accept_only_when_on;
    logic        effect_ok;
    logic        scene_recalled;
    logic [7:0]  effect_id;
    logic [7:0]  effect_variant;
    logic        level_on;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        light_on;
    logic [15:0] on_time_now;
    logic [15:0] off_wait_now;
    logic        scene_control_now;
    logic        timer_running;
    logic        invalidate_scenes;
    logic        store_scene;
    logic        trigger_effect;
    logic [7:0]  effect_id_out;
    logic [7:0]  effect_variant_out;
  } out_item_t;

  typedef struct packed {
    logic        lamp;
    logic [15:0] ron;
    logic [15:0] rwait;
    logic        scene_ctl;
  } lamp_state_t;

  typedef struct packed {
    logic [1:0] startup_mode;
    logic       startup_is_ota;
    logic       default_on_off;
  } cfg_t;

endpackage

// File: hw/rtl/timed_on_off_light_controller_top.sv
// Top level of the timed on/off light controller: registers, handshakes, config.
// The controller keeps the lamp on/off state, the remaining on-time and
// off-wait time (tenths of a second) and the global scene control flag, and
// turns each accepted command, tick, time write, level set or startup event
// into exactly one result carrying the new state, a status and the scene and
// effect request flags. An accepted item is held in an input register, goes
// through the combinational next-state logic and lands in the result register
// together with the state update, where it waits until it transfers. A new
// item is taken every cycle while the result side does not stall, and the
// state register, updated on each advance, sets that throughput.
// The result register and the input register part the two channels: the block
// keeps taking an item while a finished result waits, and stalls its input
// only when both registers are full and the result side is stalled.
// Configuration writes take effect on the next item; write them only while
// the block is idle.
module timed_on_off_light_controller_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tolc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tolc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [tolc_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [tolc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic                  in_vld_r;
  tolc_pkg::in_item_t    in_item_r;
  logic                  out_vld_r;
  tolc_pkg::out_item_t   out_item_r;
  tolc_pkg::lamp_state_t state_r;
  tolc_pkg::lamp_state_t state_nxt;
  tolc_pkg::out_item_t   res_nxt;
  tolc_pkg::cfg_t        cfg_r;
  logic                  adv;
  logic                  in_xfer;

  // Advance the held item when the result slot is free or being drained.
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  tolc_step u_step (
    .item (in_item_r),
    .cur  (state_r),
    .cfg  (cfg_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // Input register: load on transfer, drop when advanced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_xfer) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_data;
    end
  end

  // Result register: hold while stalled, clear after the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res_nxt;
    end
  end

  // Controller state advances together with the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.lamp      <= 1'b0;
      state_r.ron       <= '0;
      state_r.rwait     <= '0;
      state_r.scene_ctl <= 1'b1;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.startup_mode   <= tolc_pkg::SU_KEEP;
      cfg_r.startup_is_ota <= 1'b0;
      cfg_r.default_on_off <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tolc_pkg::CFG_STARTUP_MODE:   cfg_r.startup_mode   <= cfg_wdata[1:0];
        tolc_pkg::CFG_STARTUP_IS_OTA: cfg_r.startup_is_ota <= cfg_wdata[0];
        tolc_pkg::CFG_DEFAULT_ON_OFF: cfg_r.default_on_off <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // The shown result always mirrors the committed state.
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.light_on == state_r.lamp &&
                   out_item_r.on_time_now == state_r.ron &&
                   out_item_r.off_wait_now == state_r.rwait &&
                   out_item_r.scene_control_now == state_r.scene_ctl))
    else $error("result register out of step with state");

  // Effect fields are zero unless an effect is requested.
  a_effect_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_item_r.trigger_effect) |->
      (out_item_r.effect_id_out == 8'd0 && out_item_r.effect_variant_out == 8'd0))
    else $error("effect fields set without trigger");

  // Store and trigger travel together.
  a_store_with_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.store_scene == out_item_r.trigger_effect))
    else $error("store_scene and trigger_effect disagree");

  // An advanced item shows up as a result on the next cycle.
  a_adv_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("advanced item produced no result");

endmodule

// File: hw/rtl/tolc_step.sv
// Next-state and result logic for one item of the light controller.
module tolc_step (
  input  tolc_pkg::in_item_t    item,
  input  tolc_pkg::lamp_state_t cur,
  input  tolc_pkg::cfg_t        cfg,
  output tolc_pkg::lamp_state_t nxt,
  output tolc_pkg::out_item_t   res
);

  logic [1:0]  status;
  logic        inv;
  logic        trig;
  logic        lamp;
  logic [15:0] ron;
  logic [15:0] rwait;
  logic        sc;
  logic        was_on;
  logic        need_cur;
  logic [15:0] t_cur;
  logic [15:0] t_new;

  assign t_cur    = cur.lamp ? cur.ron : cur.rwait;
  assign need_cur = (t_cur != '0) && (t_cur != tolc_pkg::TIME_FOREVER);

  always_comb begin
    status = tolc_pkg::ST_OK;
    inv    = 1'b0;
    trig   = 1'b0;
    lamp   = cur.lamp;
    ron    = cur.ron;
    rwait  = cur.rwait;
    sc     = cur.scene_ctl;
    was_on = cur.lamp;
    unique case (item.kind)
      tolc_pkg::KIND_OFF: begin
        inv  = cur.lamp;
        lamp = 1'b0;
        ron  = '0;
      end
      tolc_pkg::KIND_ON: begin
        inv = !cur.lamp;
        if (!cur.lamp) begin
          rwait = '0;
        end
        lamp = 1'b1;
        sc   = 1'b1;
        if (cur.ron == '0) begin
          rwait = '0;
        end
      end
      tolc_pkg::KIND_TOGGLE: begin
        inv  = 1'b1;
        lamp = !cur.lamp;
        if (cur.lamp) begin
          ron = '0;
        end else begin
          rwait = '0;
          sc    = 1'b1;
        end
      end
      tolc_pkg::KIND_OFF_EFFECT: begin
        if (cur.scene_ctl) begin
          trig = 1'b1;
          if (!item.effect_ok) begin
            status = tolc_pkg::ST_EFFECT_FAIL;
          end else begin
            sc   = 1'b0;
            lamp = 1'b0;
            ron  = '0;
          end
        end else begin
          inv  = cur.lamp;
          lamp = 1'b0;
          ron  = '0;
        end
      end
      tolc_pkg::KIND_ON_RECALL: begin
        if (!cur.scene_ctl) begin
          if (!item.scene_recalled) begin
            if (!cur.lamp) begin
              rwait = '0;
            end
            lamp = 1'b1;
          end
          sc = 1'b1;
          if (cur.ron == '0) begin
            rwait = '0;
          end
        end
      end
      tolc_pkg::KIND_ON_TIMED: begin
        if (item.on_time_arg > tolc_pkg::TIME_ARG_MAX ||
            item.off_wait_arg > tolc_pkg::TIME_ARG_MAX) begin
          status = tolc_pkg::ST_CONSTRAINT;
        end else if (!(item.accept_only_when_on && !cur.lamp)) begin
          if (cur.rwait == '0 && !cur.lamp) begin
            lamp = 1'b1;
            sc   = 1'b1;
          end
          if (was_on) begin
            if (cur.ron == '0 || item.on_time_arg > cur.ron) begin
              ron = item.on_time_arg;
            end
            rwait = item.off_wait_arg;
          end else if (cur.rwait != '0) begin
            if (item.off_wait_arg < cur.rwait) begin
              rwait = item.off_wait_arg;
            end
          end else begin
            ron   = item.on_time_arg;
            rwait = item.off_wait_arg;
          end
        end
      end
      tolc_pkg::KIND_TICK: begin
        if (need_cur) begin
          if (cur.lamp) begin
            ron = cur.ron - 16'd1;
            if (ron == '0) begin
              rwait = '0;
              lamp  = 1'b0;
            end
          end else begin
            rwait = cur.rwait - 16'd1;
          end
        end
      end
      tolc_pkg::KIND_WR_ON: begin
        if (cur.ron == item.on_time_arg) begin
          status = tolc_pkg::ST_NOOP;
        end else begin
          ron = item.on_time_arg;
        end
      end
      tolc_pkg::KIND_WR_WAIT: begin
        if (cur.rwait == item.off_wait_arg) begin
          status = tolc_pkg::ST_NOOP;
        end else begin
          rwait = item.off_wait_arg;
        end
      end
      tolc_pkg::KIND_LEVEL: begin
        lamp = item.level_on;
        if (!item.level_on) begin
          ron = '0;
        end else if (cur.ron == '0) begin
          rwait = '0;
        end
      end
      tolc_pkg::KIND_STARTUP: begin
        lamp = cfg.default_on_off;
        if (!cfg.startup_is_ota) begin
          unique case (cfg.startup_mode)
            tolc_pkg::SU_OFF:    lamp = 1'b0;
            tolc_pkg::SU_ON:     lamp = 1'b1;
            tolc_pkg::SU_TOGGLE: lamp = !cfg.default_on_off;
            tolc_pkg::SU_KEEP:   lamp = cfg.default_on_off;
            default:             lamp = cfg.default_on_off;
          endcase
        end
      end
      default: begin
        // unused kinds leave the state alone
      end
    endcase
  end

  assign t_new = lamp ? ron : rwait;

  always_comb begin
    nxt.lamp      = lamp;
    nxt.ron       = ron;
    nxt.rwait     = rwait;
    nxt.scene_ctl = sc;

    res.status             = status;
    res.light_on           = lamp;
    res.on_time_now        = ron;
    res.off_wait_now       = rwait;
    res.scene_control_now  = sc;
    res.timer_running      = (t_new != '0) && (t_new != tolc_pkg::TIME_FOREVER);
    res.invalidate_scenes  = inv;
    res.store_scene        = trig;
    res.trigger_effect     = trig;
    res.effect_id_out      = trig ? item.effect_id : 8'd0;
    res.effect_variant_out = trig ? item.effect_variant : 8'd0;
  end

endmodule

// File: tb/timed_on_off_light_controller_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timed on/off light controller top level.
module timed_on_off_light_controller_top_tb;

  // Kinds with no meaning; the block must answer them with an unchanged state
  localparam logic [3:0] KIND_UNUSED_LO = 4'd11;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

  // Flag nibble for item_of: {accept_only_when_on, effect_ok, scene_recalled, level_on}
  localparam logic [3:0] F_NONE     = 4'b0000;
  localparam logic [3:0] F_ONLY     = 4'b1000;
  localparam logic [3:0] F_EFF_OK   = 4'b0100;
  localparam logic [3:0] F_RECALLED = 4'b0010;
  localparam logic [3:0] F_LEVEL    = 4'b0001;
  localparam logic [3:0] F_ALL      = 4'b1111;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  tolc_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  tolc_pkg::out_item_t             out_data;
  logic                            cfg_we;
  logic [tolc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tolc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the controller: lamp state, both timers, scene flag, registers
  logic           lamp_is_on;
  logic [15:0]    on_left;
  logic [15:0]    wait_left;
  logic           scene_ctl;
  tolc_pkg::cfg_t lamp_cfg;

  tolc_pkg::out_item_t pending_results[$];
  tolc_pkg::out_item_t oldest_expected;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        calm;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned cfg_writes;
  logic [15:0] kinds_seen;

  timed_on_off_light_controller_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("timeout: handshakes stopped making progress");
    $display("timed_on_off_light_controller_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow controller
  // ---------------------------------------------------------------------------

  // The active timer counts only while it is neither zero nor "forever"
  function automatic logic countdown_needed();
    logic [15:0] t;
    t = lamp_is_on ? on_left : wait_left;
    return (t != 16'd0) && (t != tolc_pkg::TIME_FOREVER);
  endfunction

  // On/off change by command: clear the timer that no longer applies
  function automatic void command_lamp(logic on);
    if (lamp_is_on == on) return;
    if (on) wait_left = '0;
    else on_left = '0;
    lamp_is_on = on;
  endfunction

  function automatic logic lamp_off();
    logic was_on;
    was_on = lamp_is_on;
    command_lamp(1'b0);
    on_left = '0;
    return was_on;
  endfunction

  function automatic logic lamp_on();
    logic was_off;
    was_off = !lamp_is_on;
    command_lamp(1'b1);
    scene_ctl = 1'b1;
    if (on_left == 16'd0) wait_left = '0;
    return was_off;
  endfunction

  // Apply one item to the shadow state and return the result it must produce
  function automatic tolc_pkg::out_item_t next_lamp_result(tolc_pkg::in_item_t it);
    tolc_pkg::out_item_t r;
    logic                was_on;
    r = '0;
    r.status = tolc_pkg::ST_OK;
    case (it.kind)
      tolc_pkg::KIND_OFF:    r.invalidate_scenes = lamp_off();
      tolc_pkg::KIND_ON:     r.invalidate_scenes = lamp_on();
      tolc_pkg::KIND_TOGGLE: r.invalidate_scenes = lamp_is_on ? lamp_off() : lamp_on();
      tolc_pkg::KIND_OFF_EFFECT: begin
        if (scene_ctl) begin
          // store and trigger go out even when the effect engine refuses
          r.store_scene    = 1'b1;
          r.trigger_effect = 1'b1;
          if (!it.effect_ok) begin
            r.status = tolc_pkg::ST_EFFECT_FAIL;
          end else begin
            scene_ctl = 1'b0;
            command_lamp(1'b0);
            on_left = '0;
          end
        end else begin
          r.invalidate_scenes = lamp_off();
        end
      end
      tolc_pkg::KIND_ON_RECALL: begin
        if (!scene_ctl) begin
          // a recalled scene decides the lamp itself
          if (!it.scene_recalled) command_lamp(1'b1);
          scene_ctl = 1'b1;
          if (on_left == 16'd0) wait_left = '0;
        end
      end
      tolc_pkg::KIND_ON_TIMED: begin
        if (it.on_time_arg > tolc_pkg::TIME_ARG_MAX ||
            it.off_wait_arg > tolc_pkg::TIME_ARG_MAX) begin
          r.status = tolc_pkg::ST_CONSTRAINT;
        end else if (!(it.accept_only_when_on && !lamp_is_on)) begin
          was_on = lamp_is_on;
          if (wait_left == 16'd0 && !lamp_is_on) begin
            lamp_is_on = 1'b1;
            scene_ctl  = 1'b1;
          end
          if (was_on) begin
            if (on_left > 16'd0) begin
              if (it.on_time_arg > on_left) on_left = it.on_time_arg;
            end else begin
              on_left = it.on_time_arg;
            end
            wait_left = it.off_wait_arg;
          end else if (wait_left > 16'd0) begin
            if (it.off_wait_arg < wait_left) wait_left = it.off_wait_arg;
          end else begin
            on_left   = it.on_time_arg;
            wait_left = it.off_wait_arg;
          end
        end
      end
      tolc_pkg::KIND_TICK: begin
        if (countdown_needed()) begin
          if (lamp_is_on) begin
            on_left = on_left - 16'd1;
            if (on_left == 16'd0) begin
              wait_left  = '0;
              lamp_is_on = 1'b0;
            end
          end else begin
            wait_left = wait_left - 16'd1;
          end
        end
      end
      tolc_pkg::KIND_WR_ON: begin
        if (on_left == it.on_time_arg) r.status = tolc_pkg::ST_NOOP;
        else on_left = it.on_time_arg;
      end
      tolc_pkg::KIND_WR_WAIT: begin
        if (wait_left == it.off_wait_arg) r.status = tolc_pkg::ST_NOOP;
        else wait_left = it.off_wait_arg;
      end
      tolc_pkg::KIND_LEVEL: begin
        lamp_is_on = it.level_on;
        if (!it.level_on) on_left = '0;
        else if (on_left == 16'd0) wait_left = '0;
      end
      tolc_pkg::KIND_STARTUP: begin
        // reload the stored value, then apply the start-up mode unless OTA boot
        lamp_is_on = lamp_cfg.default_on_off;
        if (!lamp_cfg.startup_is_ota) begin
          case (lamp_cfg.startup_mode)
            tolc_pkg::SU_OFF:    lamp_is_on = 1'b0;
            tolc_pkg::SU_ON:     lamp_is_on = 1'b1;
            tolc_pkg::SU_TOGGLE: lamp_is_on = !lamp_is_on;
            default:   ;
          endcase
        end
      end
      default: ;
    endcase
    r.light_on          = lamp_is_on;
    r.on_time_now       = on_left;
    r.off_wait_now      = wait_left;
    r.scene_control_now = scene_ctl;
    r.timer_running     = countdown_needed();
    if (r.trigger_effect) begin
      r.effect_id_out      = it.effect_id;
      r.effect_variant_out = it.effect_variant;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic tolc_pkg::in_item_t item_of(logic [3:0] kind, logic [15:0] t_on,
                                                 logic [15:0] t_wait, logic [3:0] flags);
    tolc_pkg::in_item_t it;
    it.kind                = kind;
    it.on_time_arg         = t_on;
    it.off_wait_arg        = t_wait;
    it.accept_only_when_on = flags[3];
    it.effect_ok           = flags[2];
    it.scene_recalled      = flags[1];
    it.level_on            = flags[0];
    it.effect_id           = 8'($urandom);
    it.effect_variant      = 8'($urandom);
    return it;
  endfunction

  // Mostly short times so ticks actually run timers out; the rest hits the
  // limits and the full range
  function automatic logic [15:0] rand_time();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(6));
      6:                return tolc_pkg::TIME_FOREVER;
      7:                return tolc_pkg::TIME_ARG_MAX;
      8:                return 16'($urandom_range(200));
      default:          return 16'($urandom);
    endcase
  endfunction

  // Weight ticks and timed-on heavily so the countdowns get exercised
  function automatic tolc_pkg::in_item_t rand_command();
    int unsigned r;
    logic [3:0]  kind;
    logic [3:0]  flags;
    r = $urandom_range(99);
    if (r < 28)      kind = tolc_pkg::KIND_TICK;
    else if (r < 42) kind = tolc_pkg::KIND_ON_TIMED;
    else if (r < 49) kind = tolc_pkg::KIND_WR_ON;
    else if (r < 55) kind = tolc_pkg::KIND_WR_WAIT;
    else if (r < 61) kind = tolc_pkg::KIND_OFF;
    else if (r < 67) kind = tolc_pkg::KIND_ON;
    else if (r < 73) kind = tolc_pkg::KIND_TOGGLE;
    else if (r < 81) kind = tolc_pkg::KIND_OFF_EFFECT;
    else if (r < 87) kind = tolc_pkg::KIND_ON_RECALL;
    else if (r < 92) kind = tolc_pkg::KIND_LEVEL;
    else if (r < 97) kind = tolc_pkg::KIND_STARTUP;
    else             kind = 4'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
    flags = {$urandom_range(9) < 3, $urandom_range(9) < 7, 1'($urandom), 1'($urandom)};
    return item_of(kind, rand_time(), rand_time(), flags);
  endfunction

  // Present one item, idling first at random, and record its expected result
  // at the edge where the transfer happens. Valid stays high on return so a
  // following call can replace the payload in the same step.
  task automatic send_command(input tolc_pkg::in_item_t it);
    int unsigned gap_pct;
    gap_pct = calm ? 0 : send_idle_pct;
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(next_lamp_result(it));
    items_sent++;
    kinds_seen[it.kind] = 1'b1;
  endtask

  // Drop valid and hold until every expected result has been taken
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write all three registers while the block is idle
  task automatic set_config(logic [1:0] mode, logic ota, logic def_on);
    wait_all_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= tolc_pkg::CFG_STARTUP_MODE;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_idx   <= tolc_pkg::CFG_STARTUP_IS_OTA;
    cfg_wdata <= tolc_pkg::CFG_DATA_W'(ota);
    @(posedge clk);
    cfg_idx   <= tolc_pkg::CFG_DEFAULT_ON_OFF;
    cfg_wdata <= tolc_pkg::CFG_DATA_W'(def_on);
    @(posedge clk);
    cfg_we <= 1'b0;
    lamp_cfg.startup_mode   = mode;
    lamp_cfg.startup_is_ota = ota;
    lamp_cfg.default_on_off = def_on;
    cfg_writes += 3;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] check failed: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  // Receiver: stall at random, except in calm stretches
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every transferred result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", out_data));
      end else begin
        oldest_expected = pending_results.pop_front();
        check_field("status", 16'(out_data.status), 16'(oldest_expected.status));
        check_field("light_on", 16'(out_data.light_on), 16'(oldest_expected.light_on));
        check_field("on_time_now", out_data.on_time_now, oldest_expected.on_time_now);
        check_field("off_wait_now", out_data.off_wait_now, oldest_expected.off_wait_now);
        check_field("scene_control_now", 16'(out_data.scene_control_now),
                    16'(oldest_expected.scene_control_now));
        check_field("timer_running", 16'(out_data.timer_running),
                    16'(oldest_expected.timer_running));
        check_field("invalidate_scenes", 16'(out_data.invalidate_scenes),
                    16'(oldest_expected.invalidate_scenes));
        check_field("store_scene", 16'(out_data.store_scene),
                    16'(oldest_expected.store_scene));
        check_field("trigger_effect", 16'(out_data.trigger_effect),
                    16'(oldest_expected.trigger_effect));
        check_field("effect_id_out", 16'(out_data.effect_id_out),
                    16'(oldest_expected.effect_id_out));
        check_field("effect_variant_out", 16'(out_data.effect_variant_out),
                    16'(oldest_expected.effect_variant_out));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk every command and the corner cases from a known state after reset:
  // lamp off, both timers zero, scene control set
  task automatic test_directed_commands();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // unused kind with both times at forever and every flag high: state must not move
    send_command(item_of(KIND_UNUSED_HI, tolc_pkg::TIME_FOREVER, tolc_pkg::TIME_FOREVER,
                         F_ALL));
    // tick with no timer running is ignored
    send_command(item_of(tolc_pkg::KIND_TICK, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_OFF, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_ON, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_TOGGLE, '0, '0, F_NONE));
    // timed-on above the limit in either time: constraint error
    send_command(item_of(tolc_pkg::KIND_ON_TIMED, tolc_pkg::TIME_FOREVER, 16'd1, F_NONE));
    send_command(item_of(tolc_pkg::KIND_ON_TIMED, 16'd1, tolc_pkg::TIME_FOREVER, F_NONE));
    // accept-only-when-on while off: dropped
    send_command(item_of(tolc_pkg::KIND_ON_TIMED, 16'd2, 16'd3, F_ONLY));
    send_command(item_of(tolc_pkg::KIND_ON_TIMED, 16'd2, 16'd3, F_NONE));
    // run the on-time out: the second tick turns the lamp off and clears wait
    send_command(item_of(tolc_pkg::KIND_TICK, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_TICK, '0, '0, F_NONE));
    // off-wait countdown, including a write of an equal value
    send_command(item_of(tolc_pkg::KIND_WR_WAIT, '0, 16'd2, F_NONE));
    send_command(item_of(tolc_pkg::KIND_WR_WAIT, '0, 16'd2, F_NONE));
    send_command(item_of(tolc_pkg::KIND_TICK, '0, '0, F_NONE));
    // timed-on while off with the wait still running only shortens the wait
    send_command(item_of(tolc_pkg::KIND_ON_TIMED, 16'd5, 16'd0, F_NONE));
    // off effect refused, then accepted
    send_command(item_of(tolc_pkg::KIND_ON, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_OFF_EFFECT, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_OFF_EFFECT, '0, '0, F_EFF_OK));
    // recall that succeeds leaves the lamp to the scene; a second is dropped
    send_command(item_of(tolc_pkg::KIND_ON_RECALL, '0, '0, F_RECALLED));
    send_command(item_of(tolc_pkg::KIND_ON_RECALL, '0, '0, F_RECALLED));
    // an accepted off effect clears scene control, so the second one is a plain off
    send_command(item_of(tolc_pkg::KIND_OFF_EFFECT, '0, '0, F_EFF_OK));
    send_command(item_of(tolc_pkg::KIND_OFF_EFFECT, '0, '0, F_EFF_OK));
    send_command(item_of(tolc_pkg::KIND_ON_RECALL, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_LEVEL, '0, '0, F_NONE));
    send_command(item_of(tolc_pkg::KIND_LEVEL, '0, '0, F_LEVEL));
    // largest legal times while on
    send_command(item_of(tolc_pkg::KIND_ON_TIMED, tolc_pkg::TIME_ARG_MAX,
                         tolc_pkg::TIME_ARG_MAX, F_ONLY));
  endtask

  // One startup event under each register setting, all modes with and
  // without an OTA boot
  task automatic startup_under(logic [1:0] mode, logic ota, logic def_on);
    set_config(mode, ota, def_on);
    send_command(item_of(tolc_pkg::KIND_STARTUP, rand_time(), rand_time(), F_ALL));
  endtask

  task automatic test_startup_modes();
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    startup_under(tolc_pkg::SU_OFF, 1'b0, 1'b1);
    startup_under(tolc_pkg::SU_ON, 1'b0, 1'b0);
    startup_under(tolc_pkg::SU_TOGGLE, 1'b0, 1'b1);
    startup_under(tolc_pkg::SU_KEEP, 1'b0, 1'b0);
    startup_under(tolc_pkg::SU_ON, 1'b1, 1'b0);
    startup_under(tolc_pkg::SU_OFF, 1'b1, 1'b1);
    startup_under(tolc_pkg::SU_TOGGLE, 1'b1, 1'b0);
    startup_under(tolc_pkg::SU_KEEP, 1'b1, 1'b1);
  endtask

  // Random traffic under one register setting and one idling profile. Every
  // 64 items a calm stretch runs with no idling on either side, and halfway
  // the sender holds off until the pipeline is empty.
  task automatic test_random_traffic(int unsigned n, int unsigned idle_pct,
                                     int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < n; i++) begin
      calm = (i % 64) >= 52;
      if (i == n / 2) wait_all_results();
      send_command(rand_command());
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    calm           = 1'b0;
    mismatches     = 0;
    items_sent     = 0;
    results_seen   = 0;
    cfg_writes     = 0;
    kinds_seen     = '0;

    // register and state values after reset
    lamp_cfg.startup_mode   = tolc_pkg::SU_KEEP;
    lamp_cfg.startup_is_ota = 1'b0;
    lamp_cfg.default_on_off = 1'b0;
    lamp_is_on = lamp_cfg.default_on_off;
    on_left    = '0;
    wait_left  = '0;
    scene_ctl  = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_startup_modes();

    // four idling profiles, each under its own register setting
    set_config(tolc_pkg::SU_ON, 1'b0, 1'b1);
    test_random_traffic(92, 0, 0);
    set_config(tolc_pkg::SU_TOGGLE, 1'b0, 1'b0);
    test_random_traffic(92, 67, 0);
    set_config(tolc_pkg::SU_KEEP, 1'b1, 1'b1);
    test_random_traffic(92, 0, 67);
    set_config(tolc_pkg::SU_OFF, 1'b0, 1'b0);
    test_random_traffic(92, 37, 37);

    // drain, then give any stray result time to show up
    wait_all_results();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("run covered %0d transfers in, %0d results compared, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("%0d distinct kinds, 8 start-up settings, 4 idling profiles, %0d failures",
             $countones(kinds_seen), mismatches);
    if (mismatches == 0) begin
      $display("timed_on_off_light_controller_top: match");
    end else begin
      $display("timed_on_off_light_controller_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tolc_pkg.sv
hw/rtl/tolc_step.sv
hw/rtl/timed_on_off_light_controller_top.sv
tb/timed_on_off_light_controller_top_tb.sv
